// ===== rtl/swm_pkg.sv =====
package swm_pkg;

  // Width and reset value of the window size register
  localparam int unsigned CFG_WIDTH = 5;
  localparam logic [CFG_WIDTH-1:0] CFG_RESET = 5'd3;

endpackage

// ===== rtl/swm_sort_cells.sv =====
module swm_sort_cells
  import swm_pkg::*;
#(
  parameter int unsigned WINDOW_MAX   = 16,
  parameter int unsigned SAMPLE_WIDTH = 32,
  localparam int unsigned CNT_W = $clog2(WINDOW_MAX + 1),
  localparam int unsigned IDX_W = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1
) (
  input  logic                           clk,
  input  logic                           upd_en,
  input  logic                           evict,
  input  logic [CNT_W-1:0]               held,
  input  logic signed [SAMPLE_WIDTH-1:0] new_val,
  input  logic signed [SAMPLE_WIDTH-1:0] old_val,
  input  logic [IDX_W-1:0]               lo_idx,
  input  logic [IDX_W-1:0]               hi_idx,
  output logic signed [SAMPLE_WIDTH:0]   median_x2
);

  logic signed [SAMPLE_WIDTH-1:0] cells_r   [WINDOW_MAX];
  logic signed [SAMPLE_WIDTH-1:0] cells_nxt [WINDOW_MAX];
  logic signed [SAMPLE_WIDTH-1:0] rem_val   [WINDOW_MAX];
  logic [WINDOW_MAX-1:0]          le_new;
  logic [WINDOW_MAX-1:0]          ge_old;
  logic [WINDOW_MAX-1:0]          rem_le;
  logic [WINDOW_MAX-1:0]          keep;
  logic signed [SAMPLE_WIDTH-1:0] lo_val;
  logic signed [SAMPLE_WIDTH-1:0] hi_val;

  // Cells are sorted, so every cell at or past the first copy of the
  // evicted value compares >= to it and shifts down by one.
  for (genvar j = 0; j < WINDOW_MAX; j++) begin : g_cell
    assign le_new[j] = (cells_r[j] <= new_val);
    assign ge_old[j] = (cells_r[j] >= old_val);

    if (j < WINDOW_MAX - 1) begin : g_shift
      assign rem_val[j] = (evict && ge_old[j]) ? cells_r[j+1] : cells_r[j];
      assign rem_le[j]  = (evict && ge_old[j]) ? le_new[j+1]  : le_new[j];
    end else begin : g_last
      assign rem_val[j] = cells_r[j];
      assign rem_le[j]  = le_new[j];
    end

    // Entries at or below the new sample stay put
    assign keep[j] = (CNT_W'(j) < held) && rem_le[j];

    if (j == 0) begin : g_head
      assign cells_nxt[j] = keep[j] ? rem_val[j] : new_val;
    end else begin : g_body
      assign cells_nxt[j] = keep[j]   ? rem_val[j]   :
                            keep[j-1] ? new_val      : rem_val[j-1];
    end
  end

  always_ff @(posedge clk) begin
    if (upd_en) begin
      cells_r <= cells_nxt;
    end
  end

  // Odd window: both indexes hit the middle cell
  assign lo_val    = cells_nxt[lo_idx];
  assign hi_val    = cells_nxt[hi_idx];
  assign median_x2 = {lo_val[SAMPLE_WIDTH-1], lo_val} + {hi_val[SAMPLE_WIDTH-1], hi_val};

endmodule

// ===== rtl/swm_out_buf.sv =====
module swm_out_buf
  import swm_pkg::*;
#(
  parameter int unsigned DATA_WIDTH = 33
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  push,
  input  logic [DATA_WIDTH-1:0] push_data,
  output logic                  full,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [DATA_WIDTH-1:0] out_data
);

  logic                  out_valid_r;
  logic [DATA_WIDTH-1:0] out_data_r;
  logic                  skid_valid_r;
  logic [DATA_WIDTH-1:0] skid_data_r;
  logic                  slot_free;

  assign slot_free = !out_valid_r || !out_stall;

  // Upstream is held off while the skid holds a result, so push never
  // lands on a full skid.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (slot_free) begin
      if (skid_valid_r) begin
        out_valid_r  <= 1'b1;
        skid_valid_r <= 1'b0;
      end else begin
        out_valid_r  <= push;
      end
    end else if (push) begin
      skid_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (slot_free) begin
      out_data_r <= skid_valid_r ? skid_data_r : push_data;
    end else if (push) begin
      skid_data_r <= push_data;
    end
  end

  assign full      = skid_valid_r;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ===== rtl/sliding_window_median.sv =====
// Running median filter over the last window_size signed samples.
// One transaction on the input channel carries a sample and a start flag;
// start empties the window before the sample is taken. Once the window
// holds window_size samples, every input transaction yields one output
// transaction carrying the median times two (exact: twice the middle value
// for an odd window, the sum of the two middle values for an even one).
// Samples taken while the window is still filling yield nothing.
// Throughput is one sample per clock while in_stall is low: the sorted
// cells compare against the new and the evicted sample in parallel and
// load their new contents in the accepting cycle, and the result is
// registered at that same edge. A two-entry output buffer (output register
// plus skid) lets inputs keep flowing while a result waits; in_stall rises
// only when both entries are occupied. Writing cfg_wr_data (window size,
// 0 acts as 1, values above WINDOW_MAX saturate) empties the window; write
// it only while the block is idle.
module sliding_window_median
  import swm_pkg::*;
#(
  parameter int unsigned WINDOW_MAX   = 16,
  parameter int unsigned SAMPLE_WIDTH = 32
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_wr_en,
  input  logic [CFG_WIDTH-1:0]           cfg_wr_data,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic signed [SAMPLE_WIDTH-1:0] in_sample,
  input  logic                           in_start_req,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic signed [SAMPLE_WIDTH:0]   out_median_x2
);

  localparam int unsigned CNT_W = $clog2(WINDOW_MAX + 1);
  localparam int unsigned IDX_W = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;

  logic [CFG_WIDTH-1:0]           window_size_r;
  logic [CNT_W-1:0]               fill_r;
  logic [IDX_W-1:0]               ptr_r;
  logic signed [SAMPLE_WIDTH-1:0] ring_r [WINDOW_MAX];

  logic [CNT_W-1:0]               win;
  logic [CNT_W-1:0]               fill_base;
  logic [IDX_W-1:0]               ptr_base;
  logic [CNT_W-1:0]               ptr_inc;
  logic                           evict;
  logic [CNT_W-1:0]               held;
  logic [CNT_W-1:0]               fill_nxt;
  logic [IDX_W-1:0]               ptr_nxt;
  logic                           emit;
  logic                           accept;
  logic                           buf_full;
  logic [IDX_W-1:0]               lo_idx;
  logic [IDX_W-1:0]               hi_idx;
  logic signed [SAMPLE_WIDTH:0]   median_x2;
  logic [SAMPLE_WIDTH:0]          out_bits;

  assign accept   = in_valid && !buf_full;
  assign in_stall = buf_full;

  // Effective window: zero acts as one, saturate at WINDOW_MAX
  always_comb begin
    if (window_size_r == '0) begin
      win = CNT_W'(1);
    end else if (int'(window_size_r) > int'(WINDOW_MAX)) begin
      win = CNT_W'(WINDOW_MAX);
    end else begin
      win = CNT_W'(window_size_r);
    end
  end

  // Start clears the window; stale counts from a shrunk window restart too
  always_comb begin
    fill_base = in_start_req ? '0 : fill_r;
    ptr_base  = in_start_req ? '0 : ptr_r;
    if (CNT_W'(ptr_base) >= win) begin
      ptr_base = '0;
    end
    if (fill_base > win) begin
      fill_base = '0;
    end
    evict    = (fill_base == win);
    held     = evict ? (win - CNT_W'(1)) : fill_base;
    fill_nxt = held + CNT_W'(1);
    emit     = (fill_nxt == win);
    ptr_inc  = CNT_W'(ptr_base) + CNT_W'(1);
    ptr_nxt  = (ptr_inc >= win) ? '0 : IDX_W'(ptr_inc);
    lo_idx   = IDX_W'((win - CNT_W'(1)) >> 1);
    hi_idx   = IDX_W'(win >> 1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      window_size_r <= CFG_RESET;
      fill_r        <= '0;
      ptr_r         <= '0;
    end else if (cfg_wr_en) begin
      window_size_r <= cfg_wr_data;
      fill_r        <= '0;
      ptr_r         <= '0;
    end else if (accept) begin
      fill_r <= fill_nxt;
      ptr_r  <= ptr_nxt;
    end
  end

  // Arrival-order ring; the slot written next holds the oldest sample
  always_ff @(posedge clk) begin
    if (accept) begin
      ring_r[ptr_base] <= in_sample;
    end
  end

  swm_sort_cells #(
    .WINDOW_MAX   (WINDOW_MAX),
    .SAMPLE_WIDTH (SAMPLE_WIDTH)
  ) u_cells (
    .clk       (clk),
    .upd_en    (accept),
    .evict     (evict),
    .held      (held),
    .new_val   (in_sample),
    .old_val   (ring_r[ptr_base]),
    .lo_idx    (lo_idx),
    .hi_idx    (hi_idx),
    .median_x2 (median_x2)
  );

  swm_out_buf #(
    .DATA_WIDTH (SAMPLE_WIDTH + 1)
  ) u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (accept && emit),
    .push_data (median_x2),
    .full      (buf_full),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_bits)
  );

  assign out_median_x2 = out_bits;

endmodule

// ===== tb/sv/sliding_window_median_test.sv =====
`timescale 1ns / 1ps

// The block keeps the last window_size samples and, once the window is full,
// returns the median times two for every input transaction. The bench keeps
// its own copy of the window and checks every output transaction against it.
module sliding_window_median_test;
  import swm_pkg::*;

  localparam int unsigned WIN_MAX = 16;
  localparam int unsigned PHASES = 8;
  localparam int unsigned PHASE_ITEMS = 50;

  // Directed rows either push a sample or rewrite the window size
  typedef enum logic {ROW_SAMPLE, ROW_WINDOW} row_kind_t;

  typedef struct packed {
    row_kind_t   kind;
    logic [31:0] sample;     // window size in [4:0] for ROW_WINDOW
    logic        start;
    logic        typed;      // 1: median_x2 below is the known answer
    logic [32:0] median_x2;
  } stim_row_t;

  // Reset window is 3. Extremes first, then duplicate eviction, then
  // window size zero (acts as 1) and an even window.
  stim_row_t directed_rows [15] = '{
    '{ROW_SAMPLE, 32'h8000_0000, 1'b1, 1'b0, 33'h0},
    '{ROW_SAMPLE, 32'h7FFF_FFFF, 1'b0, 1'b0, 33'h0},
    '{ROW_SAMPLE, 32'h0000_0000, 1'b0, 1'b1, 33'h0},           // {min,max,0}
    '{ROW_SAMPLE, 32'h7FFF_FFFF, 1'b0, 1'b1, 33'h0_FFFF_FFFE}, // {max,0,max}
    '{ROW_SAMPLE, 32'h8000_0000, 1'b0, 1'b1, 33'h0},           // {0,max,min}
    '{ROW_SAMPLE, 32'hFFFF_FFFF, 1'b1, 1'b0, 33'h0},           // start drops all
    '{ROW_SAMPLE, 32'hFFFF_FFFF, 1'b0, 1'b0, 33'h0},
    '{ROW_SAMPLE, 32'hFFFF_FFFF, 1'b0, 1'b1, 33'h1_FFFF_FFFE}, // three -1s
    '{ROW_SAMPLE, 32'h0000_0005, 1'b0, 1'b1, 33'h1_FFFF_FFFE}, // one -1 leaves
    '{ROW_WINDOW, 32'd0,         1'b0, 1'b0, 33'h0},           // zero acts as 1
    '{ROW_SAMPLE, 32'h8000_0000, 1'b0, 1'b1, 33'h1_0000_0000},
    '{ROW_SAMPLE, 32'h0000_0007, 1'b1, 1'b1, 33'h0_0000_000E},
    '{ROW_WINDOW, 32'd2,         1'b0, 1'b0, 33'h0},
    '{ROW_SAMPLE, 32'h7FFF_FFFF, 1'b0, 1'b0, 33'h0},
    '{ROW_SAMPLE, 32'h8000_0000, 1'b0, 1'b1, 33'h1_FFFF_FFFF}  // max+min
  };

  // Window size per random phase; 31 saturates at the maximum, 0 acts as 1
  logic [CFG_WIDTH-1:0] phase_windows [PHASES] = '{
    5'd31, 5'd0, 5'd16, 5'd2, 5'd5, 5'd1, 5'd8, 5'd3
  };

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   cfg_wr_en = 1'b0;
  logic [CFG_WIDTH-1:0]   cfg_wr_data = '0;
  logic                   in_valid = 1'b0;
  logic                   in_stall;
  logic signed [31:0]     in_sample = '0;
  logic                   in_start_req = 1'b0;
  logic                   out_valid;
  logic                   out_stall = 1'b0;
  logic signed [32:0]     out_median_x2;

  // Shadow window: arrival ring plus sorted copy, as the block holds them
  logic signed [31:0]     ring_q [WIN_MAX];
  logic signed [31:0]     sorted_q [WIN_MAX];
  int unsigned            held_n = 0;
  int unsigned            slot_n = 0;
  logic [CFG_WIDTH-1:0]   win_setting = CFG_RESET;

  logic signed [32:0]     median_due [$];   // medians still owed by the block
  logic signed [32:0]     median_want;
  int unsigned            fail_n = 0;
  int unsigned            send_pct = 0;     // sender idle chance, percent
  int unsigned            recv_pct = 0;     // receiver stall chance, percent

  sliding_window_median DUT (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_sample     (in_sample),
    .in_start_req  (in_start_req),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_median_x2 (out_median_x2)
  );

  always #1 clk = ~clk;

  // Takes one sample into the shadow window; returns 1 when the window is
  // full and a median is due.
  function automatic bit advance_window(input logic signed [31:0] s, input logic st,
                                        output logic signed [32:0] m2);
    int unsigned w;
    int unsigned i;
    logic signed [31:0] oldest;
    m2 = '0;
    w = (win_setting == 0) ? 1 : ((win_setting > WIN_MAX) ? WIN_MAX : win_setting);
    if (st) begin
      held_n = 0;
      slot_n = 0;
    end
    if (slot_n >= w) slot_n = 0;
    if (held_n > w) held_n = 0;
    // Full window: drop one copy of the oldest sample from the sorted list
    if (held_n == w) begin
      oldest = ring_q[slot_n];
      i = 0;
      while (i < w && sorted_q[i] != oldest) i++;
      if (i < w) begin
        for (; i + 1 < w; i++) sorted_q[i] = sorted_q[i + 1];
      end
      held_n--;
    end
    // Insertion into the sorted list, shifting larger entries up
    i = held_n;
    while (i > 0 && sorted_q[i - 1] > s) begin
      sorted_q[i] = sorted_q[i - 1];
      i--;
    end
    sorted_q[i] = s;
    held_n++;
    ring_q[slot_n] = s;
    slot_n++;
    if (slot_n >= w) slot_n = 0;
    if (held_n < w) return 1'b0;
    if (w % 2 == 1)
      m2 = {sorted_q[w / 2], 1'b0};
    else
      m2 = {sorted_q[w / 2 - 1][31], sorted_q[w / 2 - 1]} +
           {sorted_q[w / 2][31], sorted_q[w / 2]};
    return 1'b1;
  endfunction

  // Mostly full-range values, some small ones for ties, some extremes
  function automatic logic [31:0] pick_sample();
    case ($urandom_range(9))
      6, 7:    return 32'($urandom_range(8)) - 32'd4;
      8:       return 32'h8000_0000;
      9:       return 32'h7FFF_FFFF;
      default: return $urandom();
    endcase
  endfunction

  // Presents one transaction and waits for it to be taken. Idle gaps drop
  // valid; a back-to-back transaction keeps it high, so valid gets one
  // assignment per falling edge.
  task automatic send_item(input logic signed [31:0] s, input logic st,
                           input logic typed, input logic signed [32:0] typed_m2);
    logic signed [32:0] m2;
    @(negedge clk);
    while ($urandom_range(99) < send_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid     <= 1'b1;
    in_sample    <= s;
    in_start_req <= st;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (advance_window(s, st, m2))
      median_due = {median_due, (typed ? typed_m2 : m2)};
  endtask

  // Stops sending until every owed median is out, then lets the pipeline
  // settle (a transaction that gives no result may still be in flight).
  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (median_due.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  // Window size writes happen only with the block idle; they empty the window
  task automatic write_window(input logic [CFG_WIDTH-1:0] size);
    drain();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= size;
    @(negedge clk);
    cfg_wr_en   <= 1'b0;
    win_setting = size;
    held_n = 0;
    slot_n = 0;
  endtask

  // Receiver back-pressure, redrawn every cycle
  always @(negedge clk) begin
    out_stall <= ($urandom_range(99) < recv_pct);
  end

  // Output check: every accepted transaction against the oldest owed median
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (median_due.size() == 0) begin
        $error("median_x2: no result owed, actual %0d", out_median_x2);
        fail_n++;
      end else begin
        median_want = median_due.pop_front();
        if (out_median_x2 !== median_want) begin
          $error("median_x2: expected %0d, actual %0d", median_want, out_median_x2);
          fail_n++;
        end
      end
    end
  end

  initial begin
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;

    // Directed part, no idling
    foreach (directed_rows[r]) begin
      if (directed_rows[r].kind == ROW_WINDOW)
        write_window(directed_rows[r].sample[CFG_WIDTH-1:0]);
      else
        send_item(directed_rows[r].sample, directed_rows[r].start,
                  directed_rows[r].typed, directed_rows[r].median_x2);
    end

    // Random phases: idling pattern cycles through none / sender / receiver
    // / both, while the window size moves through its extremes.
    for (int unsigned p = 0; p < PHASES; p++) begin
      write_window(phase_windows[p]);
      case (p % 4)
        0:       begin send_pct = 0;  recv_pct = 0;  end
        1:       begin send_pct = 75; recv_pct = 0;  end
        2:       begin send_pct = 0;  recv_pct = 75; end
        default: begin send_pct = 9;  recv_pct = 9;  end
      endcase
      for (int unsigned k = 0; k < PHASE_ITEMS; k++) begin
        // Once, the sender holds off until the output side has caught up
        if (p == 1 && k == PHASE_ITEMS / 2) drain();
        send_item(pick_sample(), ($urandom_range(39) == 0), 1'b0, '0);
      end
    end

    drain();
    repeat (10) @(posedge clk);
    if (fail_n == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

  // Hang guard, far beyond the slowest legal run
  initial begin
    #1_000_000;
    $display("Test completed with failures");
    $finish;
  end

endmodule

// ===== files.f =====
rtl/swm_pkg.sv
rtl/swm_sort_cells.sv
rtl/swm_out_buf.sv
rtl/sliding_window_median.sv
tb/sv/sliding_window_median_test.sv
